// ===== src/tlv_record_validator_unit_defines.svh =====
// Assertion macros for the checker file of the record validator.
`ifndef TLV_RECORD_VALIDATOR_UNIT_DEFINES_SVH
`define TLV_RECORD_VALIDATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TLVV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("record validator check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TLVV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("record validator check failed");

`endif

// ===== src/tlvv_pkg.sv =====
`default_nettype none

package tlvv_pkg;

    localparam int unsigned HDR_BYTES = 8;
    localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);
    localparam int unsigned ID_W = 16;
    localparam int unsigned LEN_W = 32;
    localparam int unsigned PAY_W = 28;
    localparam int unsigned TRACKED_IDS = 31;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 31;

    localparam logic [PAY_W-1:0] MAX_PAYLOAD_RESET = PAY_W'(128 * 1024 * 1024);
    localparam logic [TRACKED_IDS-1:0] REQ_MASK_RESET = 31'h0040_0100;

    localparam logic [7:0] CRIT_FLAG = 8'h01;
    localparam logic [LEN_W-1:0] TIME_BYTES = 32'd20;

    localparam logic [7:0] TYP_BYTE = 8'd1;
    localparam logic [7:0] TYP_HALF = 8'd2;
    localparam logic [7:0] TYP_WORD = 8'd3;
    localparam logic [7:0] TYP_DWORD = 8'd4;
    localparam logic [7:0] TYP_TEXT = 8'd5;
    localparam logic [7:0] TYP_STAMP = 8'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_MASK = 2'd1;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT_HDR,
        ST_BAD_LEN,
        ST_DUP,
        ST_BAD_TYPE,
        ST_CRIT_UNKNOWN,
        ST_MISSING
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        status_t                status;
        logic [TRACKED_IDS-1:0] fields_seen;
        logic [ID_W-1:0]        bad_field;
    } result_t;

    typedef struct packed {
        logic [PAY_W-1:0]       max_payload;
        logic [TRACKED_IDS-1:0] required_mask;
    } cfg_t;

endpackage

`default_nettype wire

// ===== src/tlvv_cfg_regs.sv =====
`default_nettype none

module tlvv_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tlvv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tlvv_pkg::CFG_DATA_W-1:0]    cfg_data,
    output tlvv_pkg::cfg_t                          cfg
);

    logic [tlvv_pkg::PAY_W-1:0]       max_payload_reg;
    logic [tlvv_pkg::TRACKED_IDS-1:0] required_mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg   <= tlvv_pkg::MAX_PAYLOAD_RESET;
            required_mask_reg <= tlvv_pkg::REQ_MASK_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tlvv_pkg::CFG_MAX_PAYLOAD:
                    max_payload_reg <= cfg_data[tlvv_pkg::PAY_W-1:0];
                tlvv_pkg::CFG_REQUIRED_MASK:
                    required_mask_reg <= cfg_data[tlvv_pkg::TRACKED_IDS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.max_payload   = max_payload_reg;
    assign cfg.required_mask = required_mask_reg;

endmodule

`default_nettype wire

// ===== src/tlvv_parser.sv =====
`default_nettype none

module tlvv_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire tlvv_pkg::item_t  item,
    input  wire tlvv_pkg::cfg_t   cfg,
    output tlvv_pkg::result_t     result
);

    typedef struct packed {
        tlvv_pkg::status_t                code;
        logic [tlvv_pkg::TRACKED_IDS-1:0] seen;
    } check_t;

    logic [tlvv_pkg::HDR_IDX_W-1:0]        hdr_idx_reg, hdr_idx_next;
    logic [tlvv_pkg::HDR_BYTES*8-1:0]      hdr_reg, hdr_next;
    logic [tlvv_pkg::PAY_W-1:0]            pay_left_reg, pay_left_next;
    logic [tlvv_pkg::TRACKED_IDS-1:0]      seen_reg, seen_next;
    tlvv_pkg::status_t                     err_reg, err_next;
    logic [tlvv_pkg::ID_W-1:0]             fail_field_reg, fail_field_next;

    logic [tlvv_pkg::HDR_BYTES*8-1:0]      hdr_shift;
    logic [tlvv_pkg::HDR_BYTES*8-1:0]      chk_hdr;
    logic [tlvv_pkg::LEN_W-1:0]            new_len;
    logic                                  in_payload;
    logic                                  hdr_done;
    logic                                  len_over;
    logic                                  do_check;
    check_t                                chk;

    function automatic check_t item_check(
        input logic [tlvv_pkg::HDR_BYTES*8-1:0] hdr,
        input logic [tlvv_pkg::TRACKED_IDS-1:0] seen
    );
        logic [tlvv_pkg::ID_W-1:0]        f;
        logic [7:0]                       t;
        logic [7:0]                       flags;
        logic [tlvv_pkg::LEN_W-1:0]       n;
        logic                             tracked;
        logic [tlvv_pkg::TRACKED_IDS-1:0] bit_mask;
        logic                             ok;
        check_t                           res;
        f        = hdr[63:48];
        t        = hdr[47:40];
        flags    = hdr[39:32];
        n        = hdr[31:0];
        tracked  = (f[15:5] == '0) && (f[4:0] != '0);
        bit_mask = tlvv_pkg::TRACKED_IDS'(1) << (f[4:0] - 5'd1);
        res.code = tlvv_pkg::ST_OK;
        res.seen = seen;
        ok       = 1'b1;
        if (tracked && ((seen & bit_mask) != '0))
        begin
            res.code = tlvv_pkg::ST_DUP;
        end
        else
        begin
            if (tracked)
            begin
                res.seen = seen | bit_mask;
            end
            case (f) inside
                16'd1, 16'd2, 16'd3:
                    ok = (t == tlvv_pkg::TYP_HALF) && (n == 32'd2);
                16'd4, 16'd23, 16'd24:
                    ok = (t == tlvv_pkg::TYP_WORD) && (n == 32'd4);
                16'd5:
                    ok = (t == tlvv_pkg::TYP_DWORD) && (n == 32'd8);
                16'd6, 16'd7:
                    ok = (t == tlvv_pkg::TYP_STAMP) && (n == tlvv_pkg::TIME_BYTES);
                [16'd8:16'd14], 16'd16, 16'd17, 16'd21, 16'd22:
                    ok = (t == tlvv_pkg::TYP_TEXT);
                16'd15, [16'd18:16'd20]:
                    ok = 1'b1;
                16'd25:
                    ok = (t == tlvv_pkg::TYP_BYTE) && (n == 32'd1);
                default:
                begin
                    if ((flags & tlvv_pkg::CRIT_FLAG) != '0)
                    begin
                        res.code = tlvv_pkg::ST_CRIT_UNKNOWN;
                    end
                end
            endcase
            if (!ok)
            begin
                res.code = tlvv_pkg::ST_BAD_TYPE;
            end
        end
        return res;
    endfunction

    always_comb
    begin
        hdr_shift  = {hdr_reg[tlvv_pkg::HDR_BYTES*8-9:0], item.data_byte};
        in_payload = (pay_left_reg != '0);
        hdr_done   = !in_payload
                     && (hdr_idx_reg == tlvv_pkg::HDR_IDX_W'(tlvv_pkg::HDR_BYTES - 1));
        new_len    = hdr_shift[tlvv_pkg::LEN_W-1:0];
        len_over   = new_len > tlvv_pkg::LEN_W'(cfg.max_payload);
        chk_hdr    = in_payload ? hdr_reg : hdr_shift;
        chk        = item_check(chk_hdr, seen_reg);
        do_check   = (err_reg == tlvv_pkg::ST_OK)
                     && (in_payload ? (pay_left_reg == tlvv_pkg::PAY_W'(1))
                                    : (hdr_done && !len_over && (new_len == '0)));

        hdr_idx_next    = hdr_idx_reg;
        hdr_next        = hdr_reg;
        pay_left_next   = pay_left_reg;
        seen_next       = seen_reg;
        err_next        = err_reg;
        fail_field_next = fail_field_reg;

        if (err_reg == tlvv_pkg::ST_OK)
        begin
            if (in_payload)
            begin
                pay_left_next = pay_left_reg - tlvv_pkg::PAY_W'(1);
            end
            else
            begin
                hdr_next = hdr_shift;
                if (hdr_done)
                begin
                    hdr_idx_next = '0;
                    if (len_over)
                    begin
                        err_next        = tlvv_pkg::ST_BAD_LEN;
                        fail_field_next = hdr_shift[63:48];
                    end
                    else
                    begin
                        pay_left_next = new_len[tlvv_pkg::PAY_W-1:0];
                    end
                end
                else
                begin
                    hdr_idx_next = hdr_idx_reg + tlvv_pkg::HDR_IDX_W'(1);
                end
            end
            if (do_check)
            begin
                seen_next = chk.seen;
                err_next  = chk.code;
                if (chk.code != tlvv_pkg::ST_OK)
                begin
                    fail_field_next = chk_hdr[63:48];
                end
            end
        end

        result.status      = err_next;
        result.fields_seen = seen_next;
        result.bad_field   = fail_field_next;
        if (err_next == tlvv_pkg::ST_OK)
        begin
            if (pay_left_next != '0)
            begin
                result.status    = tlvv_pkg::ST_BAD_LEN;
                result.bad_field = hdr_next[63:48];
            end
            else if (hdr_idx_next != '0)
            begin
                result.status    = tlvv_pkg::ST_SHORT_HDR;
                result.bad_field = '0;
            end
            else if ((seen_next & cfg.required_mask) != cfg.required_mask)
            begin
                result.status    = tlvv_pkg::ST_MISSING;
                result.bad_field = '0;
            end
        end

        if (item.last_byte)
        begin
            hdr_idx_next    = '0;
            hdr_next        = '0;
            pay_left_next   = '0;
            seen_next       = '0;
            err_next        = tlvv_pkg::ST_OK;
            fail_field_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_idx_reg    <= '0;
            hdr_reg        <= '0;
            pay_left_reg   <= '0;
            seen_reg       <= '0;
            err_reg        <= tlvv_pkg::ST_OK;
            fail_field_reg <= '0;
        end
        else if (step)
        begin
            hdr_idx_reg    <= hdr_idx_next;
            hdr_reg        <= hdr_next;
            pay_left_reg   <= pay_left_next;
            seen_reg       <= seen_next;
            err_reg        <= err_next;
            fail_field_reg <= fail_field_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/tlv_record_validator_unit.sv =====
// Record validator for type-length-value records, one byte per transaction.
// The item channel (item_valid, item_ready, item) carries a data byte and a
// last-byte mark; the result channel (result_valid, result_ready, result)
// carries one status, seen-field mask and failing field id per record.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes the maximum payload length (index 0) and the required-field mask
// (index 1); it is always ready. It must be written only while the block is idle,
// which the block itself does not enforce. An input register feeds the parser,
// whose header, payload and check logic update once per byte into a result
// register, loaded when the parser steps on a record's last byte. Reset clears
// the parser state and restores both configuration registers. Throughput is one
// byte per cycle while no result waits on result_ready; while one waits, other
// bytes keep flowing, but a last byte holds in the input register until the
// result slot frees, and item_ready drops once that register is occupied and stuck.
`default_nettype none

module tlv_record_validator_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_ready,
    input  wire tlvv_pkg::item_t                    item,
    output logic                                    result_valid,
    input  wire logic                               result_ready,
    output tlvv_pkg::result_t                       result,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tlvv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tlvv_pkg::CFG_DATA_W-1:0]    cfg_data
);

    tlvv_pkg::item_t   item_reg;
    logic              item_valid_reg;
    tlvv_pkg::result_t result_reg;
    logic              result_valid_reg, result_valid_next;
    tlvv_pkg::result_t parse_result;
    tlvv_pkg::cfg_t    cfg;
    logic              step;

    tlvv_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlvv_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (parse_result)
    );

    assign step = item_valid_reg
                  && (!item_reg.last_byte || !result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || step;

    always_comb
    begin
        result_valid_next = result_valid_reg && !result_ready;
        if (step && item_reg.last_byte)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (step && item_reg.last_byte)
        begin
            result_reg <= parse_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== src/tlvv_checker.sv =====
`default_nettype none
`include "tlv_record_validator_unit_defines.svh"

module tlvv_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               result_valid,
    input wire logic                               result_ready,
    input wire tlvv_pkg::result_t                  result
);

    logic no_field_status;
    logic dup_status;
    logic type_status;

    assign no_field_status = (result.status == tlvv_pkg::ST_OK)
                             || (result.status == tlvv_pkg::ST_SHORT_HDR)
                             || (result.status == tlvv_pkg::ST_MISSING);
    assign dup_status  = (result.status == tlvv_pkg::ST_DUP);
    assign type_status = (result.status == tlvv_pkg::ST_BAD_TYPE);

    // A pending result must hold until the receiver takes it.
    `TLVV_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))
    // Success, a short header and a missing field name no failing field.
    `TLVV_ASSERT_NOW(a_no_field, result_valid && no_field_status, result.bad_field == '0)
    // Only tracked ids can be reported as duplicates.
    `TLVV_ASSERT_NOW(a_dup_id, result_valid && dup_status, (result.bad_field != '0) && (result.bad_field <= 16'd31))
    // A wrong type or size is reported only for a known field id.
    `TLVV_ASSERT_NOW(a_type_id, result_valid && type_status, (result.bad_field != '0) && (result.bad_field <= 16'd25))

endmodule

bind tlv_record_validator_unit tlvv_checker u_checker (.*);

`default_nettype wire
